@@ hw/rtl/b64e_pkg.sv @@
// Package for the base64 stream encoder.
// Holds the group record type, the queue depth default and the alphabet lookup.
`default_nettype none

package b64e_pkg;

  localparam int QueueDepthDef = 2;

  localparam logic [6:0] PadChar   = 7'h3D;
  localparam logic [6:0] UpperBase = 7'h41;
  localparam logic [6:0] LowerBase = 7'h61;
  localparam logic [6:0] DigitBase = 7'h30;
  localparam logic [6:0] PlusChar  = 7'h2B;
  localparam logic [6:0] SlashChar = 7'h2F;

  localparam logic [1:0] HeldNone = 2'd0;
  localparam logic [1:0] HeldOne  = 2'd1;
  localparam logic [1:0] HeldTwo  = 2'd2;

  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [1:0] held;
    logic       fin;
  } group_t;

  function automatic logic [6:0] sextet_char(input logic [5:0] v);
    logic [6:0] r;
    if (v < 6'd26) begin
      r = UpperBase + {1'b0, v};
    end else if (v < 6'd52) begin
      r = LowerBase + {1'b0, v - 6'd26};
    end else if (v < 6'd62) begin
      r = DigitBase + {1'b0, v - 6'd52};
    end else if (v == 6'd62) begin
      r = PlusChar;
    end else begin
      r = SlashChar;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/b64e_in_if.sv @@
// Input channel of the base64 encoder: one raw byte per item.
// Stands alone; carries valid, ready and the byte payload.
`default_nettype none

interface b64e_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/b64e_out_if.sv @@
// Output channel of the base64 encoder: one ASCII character per item.
// Stands alone; carries valid, ready and the character payload.
`default_nettype none

interface b64e_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] char_code;
  logic       run_end;

  modport source (output valid, output char_code, output run_end, input ready);
  modport sink   (input valid, input char_code, input run_end, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/b64e_front.sv @@
// Front end of the base64 encoder: gathers bytes into groups of up to three.
// Uses b64e_pkg for the group record; pushes finished groups into the queue.
`default_nettype none

module b64e_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  output logic                 ready_o,
  input  wire logic [7:0]      data_byte_i,
  input  wire logic            final_byte_i,
  input  wire logic            q_full_i,
  output logic                 push_o,
  output b64e_pkg::group_t     group_o
);
  import b64e_pkg::*;

  logic [1:0]  held_q, held_d;
  logic [15:0] pend_q, pend_d;
  logic        accept;
  logic        hold_byte;

  assign ready_o   = !q_full_i;
  assign accept    = valid_i && ready_o;
  assign hold_byte = !held_q[1] && !final_byte_i;
  assign push_o    = accept && !hold_byte;

  always_comb begin
    group_o.held = held_q[1] ? HeldTwo : held_q;
    group_o.fin  = final_byte_i;
    group_o.b0   = (held_q == HeldNone) ? data_byte_i : pend_q[15:8];
    group_o.b1   = (held_q == HeldOne) ? data_byte_i :
                   (held_q[1] ? pend_q[7:0] : 8'h00);
    group_o.b2   = held_q[1] ? data_byte_i : 8'h00;
  end

  always_comb begin
    held_d = held_q;
    pend_d = pend_q;
    if (accept) begin
      if (hold_byte) begin
        held_d = held_q + 2'd1;
        if (held_q == HeldNone) begin
          pend_d = {data_byte_i, 8'h00};
        end else begin
          pend_d = {pend_q[15:8], data_byte_i};
        end
      end else begin
        held_d = HeldNone;
        pend_d = 16'h0000;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= HeldNone;
    end else begin
      held_q <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
  end

endmodule

`default_nettype wire

@@ hw/rtl/b64e_queue.sv @@
// Short group queue between the front and back ends of the base64 encoder.
// Uses b64e_pkg for the group record; first in, first out, shown head.
`default_nettype none

module b64e_queue #(
  parameter int Depth = b64e_pkg::QueueDepthDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire b64e_pkg::group_t data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output b64e_pkg::group_t      data_o
);
  import b64e_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  group_t          mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/b64e_back.sv @@
// Back end of the base64 encoder: turns one queued group into four characters.
// Uses b64e_pkg for the group record and the alphabet; drives the output register.
`default_nettype none

module b64e_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             q_valid_i,
  input  wire b64e_pkg::group_t group_i,
  output logic                  pop_o,
  output logic                  valid_o,
  input  wire logic             ready_i,
  output logic [6:0]            char_code_o,
  output logic                  run_end_o
);
  import b64e_pkg::*;

  logic [1:0] idx_q, idx_d;
  logic       valid_q, valid_d;
  logic [6:0] char_q, char_d;
  logic       end_q, end_d;
  logic [5:0] sextet;
  logic       pad;
  logic       load;

  assign load    = q_valid_i && (!valid_q || ready_i);
  assign pop_o   = load && (idx_q == 2'd3);
  assign valid_o = valid_q;
  assign char_code_o = char_q;
  assign run_end_o   = end_q;

  always_comb begin
    case (idx_q)
      2'd0: begin
        sextet = group_i.b0[7:2];
        pad    = 1'b0;
      end
      2'd1: begin
        sextet = {group_i.b0[1:0], group_i.b1[7:4]};
        pad    = 1'b0;
      end
      2'd2: begin
        sextet = {group_i.b1[3:0], group_i.b2[7:6]};
        pad    = (group_i.held == HeldNone);
      end
      2'd3: begin
        sextet = group_i.b2[5:0];
        pad    = (group_i.held != HeldTwo);
      end
      default: begin
        sextet = 6'd0;
        pad    = 1'b0;
      end
    endcase
  end

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    char_d  = char_q;
    end_d   = end_q;
    if (load) begin
      idx_d   = idx_q + 2'd1;
      valid_d = 1'b1;
      char_d  = pad ? PadChar : sextet_char(sextet);
      end_d   = (idx_q == 2'd3) && group_i.fin;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    end_q  <= end_d;
  end

endmodule

`default_nettype wire

@@ hw/rtl/base64_stream_encoder_top.sv @@
// Base64 stream encoder, padded, one raw byte in and one ASCII character out per item.
// An input item is taken whenever the group queue has room; a byte that completes a
// group is queued, and its first character then goes into the output register.
// Each group of up to three bytes leaves as four characters, one per cycle when the
// output is ready, so the output register limits the sustained rate.
// Reset clears the held byte count, the queue and the output valid.
`default_nettype none

module base64_stream_encoder_top #(
  parameter int QueueDepth = b64e_pkg::QueueDepthDef
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  b64e_in_if.sink     in_i,
  b64e_out_if.source  out_o
);
  import b64e_pkg::*;

  logic   q_full;
  logic   push;
  group_t push_group;
  logic   q_valid;
  logic   pop;
  group_t head_group;

  b64e_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (in_i.valid),
    .ready_o      (in_i.ready),
    .data_byte_i  (in_i.data_byte),
    .final_byte_i (in_i.final_byte),
    .q_full_i     (q_full),
    .push_o       (push),
    .group_o      (push_group)
  );

  b64e_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_group),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (head_group)
  );

  b64e_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .group_i     (head_group),
    .pop_o       (pop),
    .valid_o     (out_o.valid),
    .ready_i     (out_o.ready),
    .char_code_o (out_o.char_code),
    .run_end_o   (out_o.run_end)
  );

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
// Self-checking bench for base64_stream_encoder_top: a byte driver, a character monitor
// and an encoder predictor that checks every character and its run_end flag in order.
// Depends on b64e_pkg, b64e_in_if, b64e_out_if and the encoder top level.
module testbench;
  import b64e_pkg::*;

  typedef struct {
    logic [7:0] data_byte;
    logic       final_byte;
  } raw_byte_t;

  typedef struct {
    logic [6:0] char_code;
    logic       run_end;
  } b64_char_t;

  localparam string Alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  b64e_in_if  byte_ch ();
  b64e_out_if char_ch ();

  base64_stream_encoder_top DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (byte_ch),
    .out_o (char_ch)
  );

  raw_byte_t  byte_queue[$];
  b64_char_t  expected_chars[$];
  logic [15:0] held_bytes = '0;
  logic [1:0]  held_count = HeldNone;
  int bytes_queued = 0;
  int bytes_accepted = 0;
  int error_count = 0;
  int send_gap = 0;
  int stall_left = 0;
  logic byte_taken = 1'b0;
  logic idle_on = 1'b0;
  logic hold_output = 1'b0;

  initial begin
    byte_ch.valid = 1'b0;
    byte_ch.data_byte = '0;
    byte_ch.final_byte = 1'b0;
    char_ch.ready = 1'b0;
  end

  always #2 clk = ~clk;

  function automatic logic [6:0] b64_symbol(input logic [5:0] v);
    byte c;
    c = Alphabet[v];
    return c[6:0];
  endfunction

  // Mirrors the encoder: holds bytes until a group is complete or the stream ends.
  function automatic void encode_byte(input logic [7:0] b, input logic fin);
    logic [7:0] b0, b1, b2;
    logic [23:0] grp;
    b64_char_t ch;
    int nbytes;
    if (held_count != HeldTwo && !fin) begin
      if (held_count == HeldNone) begin
        held_bytes = {b, 8'h00};
        held_count = HeldOne;
      end else begin
        held_bytes = {held_bytes[15:8], b};
        held_count = HeldTwo;
      end
      return;
    end
    nbytes = int'(held_count) + 1;
    b0 = (held_count == HeldNone) ? b : held_bytes[15:8];
    b1 = (held_count == HeldOne) ? b : ((held_count == HeldTwo) ? held_bytes[7:0] : 8'h00);
    b2 = (held_count == HeldTwo) ? b : 8'h00;
    grp = {b0, b1, b2};
    for (int k = 0; k < 4; k++) begin
      ch.char_code = (k <= nbytes) ? b64_symbol(grp[23 - 6 * k -: 6]) : PadChar;
      ch.run_end = (k == 3) && fin;
      expected_chars.push_back(ch);
    end
    held_bytes = '0;
    held_count = HeldNone;
  endfunction

  task automatic queue_byte(input logic [7:0] b, input logic fin);
    raw_byte_t item;
    item.data_byte = b;
    item.final_byte = fin;
    byte_queue.push_back(item);
    bytes_queued++;
  endtask

  task automatic queue_streams(input int count);
    int n;
    int len;
    n = 0;
    while (n < count) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 9);
      for (int i = 0; i < len; i++) begin
        queue_byte(8'($urandom_range(0, 255)), i == len - 1);
      end
      n += len;
    end
  endtask

  // Byte driver: a new item is offered once the previous one has been taken.
  always @(negedge clk) begin
    raw_byte_t nxt;
    if (rst_n && (!byte_ch.valid || byte_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        byte_ch.valid <= 1'b0;
      end else if (byte_queue.size() != 0) begin
        nxt = byte_queue.pop_front();
        byte_ch.valid <= 1'b1;
        byte_ch.data_byte <= nxt.data_byte;
        byte_ch.final_byte <= nxt.final_byte;
        if (idle_on && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 7);
      end else begin
        byte_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n || hold_output) begin
      char_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      char_ch.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 6);
      char_ch.ready <= 1'b0;
    end else begin
      char_ch.ready <= 1'b1;
    end
  end

  // Predicts on each accepted byte, then checks each accepted character.
  always @(posedge clk) begin
    b64_char_t exp_ch;
    byte_taken = rst_n && byte_ch.valid && byte_ch.ready;
    if (byte_taken) begin
      encode_byte(byte_ch.data_byte, byte_ch.final_byte);
      bytes_accepted++;
    end
    if (rst_n && char_ch.valid && char_ch.ready) begin
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected character, expected none, actual %h run_end %b",
                 $time, char_ch.char_code, char_ch.run_end);
        error_count++;
      end else begin
        exp_ch = expected_chars.pop_front();
        if (char_ch.char_code !== exp_ch.char_code) begin
          $display("%0t: char_code mismatch, expected %h, actual %h",
                   $time, exp_ch.char_code, char_ch.char_code);
          error_count++;
        end
        if (char_ch.run_end !== exp_ch.run_end) begin
          $display("%0t: run_end mismatch, expected %b, actual %b",
                   $time, exp_ch.run_end, char_ch.run_end);
          error_count++;
        end
      end
    end
  end

  // The output side holds off long enough for the encoder to fill and stall its input.
  initial begin
    wait (bytes_accepted >= 25);
    @(posedge clk);
    hold_output = 1'b1;
    repeat (100) @(posedge clk);
    hold_output = 1'b0;
  end

  initial begin
    #400000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Single-byte, two-byte and three-byte streams at the byte extremes.
    queue_byte(8'h00, 1'b1);
    queue_byte(8'hFF, 1'b1);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFF, 1'b1);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b1);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b1);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFF, 1'b1);
    queue_byte(8'hFB, 1'b0);
    queue_byte(8'hEF, 1'b0);
    queue_byte(8'hBE, 1'b1);
    // A full group that does not end the stream, then a final lone byte.
    queue_byte(8'h4D, 1'b0);
    queue_byte(8'h61, 1'b0);
    queue_byte(8'h6E, 1'b0);
    queue_byte(8'h5A, 1'b1);
    // Two full groups, the second of which ends the stream.
    queue_byte(8'h01, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'h7F, 1'b0);
    queue_byte(8'hFE, 1'b0);
    queue_byte(8'h10, 1'b0);
    queue_byte(8'h3C, 1'b1);

    idle_on = 1'b1;
    queue_streams(30);

    // The sender pauses until every expected character has come out.
    wait (bytes_accepted == bytes_queued);
    wait (expected_chars.size() == 0);

    queue_streams(30);
    wait (byte_queue.size() == 0);
    idle_on = 1'b0;
    queue_streams(15);

    wait (bytes_accepted == bytes_queued);
    wait (expected_chars.size() == 0);
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
